// File: design/dta_pkg.sv
// Shared constants, widths and helper functions for the dihedral angle pipeline.
// No dependencies; every other design file refers to it by scoped names.
package dta_pkg;

  localparam int COORD_W      = 24;
  localparam int ANGLE_W      = 16;
  localparam int NORM_FIT     = 29;
  localparam int PROD_FIT     = 30;
  localparam int SQRT_STEPS   = 31;
  localparam int RAD_W        = 2 * SQRT_STEPS;
  localparam int CORDIC_STEPS = 17;
  localparam int CORDIC_W     = 36;
  localparam int ZW           = 19;
  localparam int PI_Q16       = 205887;
  localparam int PI_Q13       = 25736;

  // Arctangent of 2^-i, scaled by 65536 and rounded.
  function automatic logic signed [ZW-1:0] atan_q16(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:       a = 19'sd51472;
      1:       a = 19'sd30386;
      2:       a = 19'sd16055;
      3:       a = 19'sd8150;
      4:       a = 19'sd4091;
      5:       a = 19'sd2047;
      6:       a = 19'sd1024;
      7:       a = 19'sd512;
      8:       a = 19'sd256;
      9:       a = 19'sd128;
      10:      a = 19'sd64;
      11:      a = 19'sd32;
      12:      a = 19'sd16;
      13:      a = 19'sd8;
      14:      a = 19'sd4;
      15:      a = 19'sd2;
      16:      a = 19'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    return m;
  endfunction

  // Smallest right shift that brings the magnitude below 2^bits.
  function automatic logic [5:0] fit_shift(input logic [63:0] m, input int bits);
    int len;
    len = 0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) len = i + 1;
    end
    return (len > bits) ? 6'(len - bits) : 6'd0;
  endfunction

endpackage

// File: design/dta_isqrt.sv
// Pipelined integer square root, one result bit per stage, bubble-collapsing stall.
// Depends on dta_pkg for the radicand width and the number of steps.
module dta_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [dta_pkg::RAD_W-1:0]    in_rad,
  input  logic [SIDE_W-1:0]            in_side,
  input  logic                         ld_dn,
  output logic                         ld_up,
  output logic                         out_valid,
  output logic [dta_pkg::SQRT_STEPS-1:0] out_root,
  output logic [SIDE_W-1:0]            out_side
);

  localparam int N  = dta_pkg::SQRT_STEPS;
  localparam int RW = dta_pkg::RAD_W + 1;

  logic          v_r    [N];
  logic [RW-1:0] rem_r  [N];
  logic [RW-1:0] root_r [N];
  logic [SIDE_W-1:0] side_r [N];
  logic          ld     [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic          pv;
    logic [RW-1:0] prem, proot, trial, rem_nxt, root_nxt;
    logic [SIDE_W-1:0] pside;
    localparam logic [RW-1:0] BITC = RW'(1) << (2 * (N - 1 - k));

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = RW'(in_rad);
      assign proot = '0;
      assign pside = in_side;
    end else begin : g_rest
      assign pv    = v_r[k-1];
      assign prem  = rem_r[k-1];
      assign proot = root_r[k-1];
      assign pside = side_r[k-1];
    end

    if (k == N - 1) begin : g_last_ld
      assign ld[k] = !v_r[k] || ld_dn;
    end else begin : g_mid_ld
      assign ld[k] = !v_r[k] || ld[k+1];
    end

    always_comb begin
      trial = proot + BITC;
      if (prem >= trial) begin
        rem_nxt  = prem - trial;
        root_nxt = (proot >> 1) + BITC;
      end else begin
        rem_nxt  = prem;
        root_nxt = proot >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= pside;
      end
    end
  end

  assign ld_up     = ld[0];
  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1][N-1:0];
  assign out_side  = side_r[N-1];

endmodule

// File: design/dta_cordic.sv
// Pipelined CORDIC vectoring unit giving the first-quadrant angle in Q.16.
// Depends on dta_pkg for the arctangent table and the datapath widths.
module dta_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [dta_pkg::SQRT_STEPS-1:0]     in_x,
  input  logic [dta_pkg::SQRT_STEPS-1:0]     in_y,
  input  logic [SIDE_W-1:0]                  in_side,
  input  logic                               ld_dn,
  output logic                               ld_up,
  output logic                               out_valid,
  output logic signed [dta_pkg::ZW-1:0]      out_z,
  output logic [SIDE_W-1:0]                  out_side
);

  localparam int N  = dta_pkg::CORDIC_STEPS;
  localparam int W  = dta_pkg::CORDIC_W;
  localparam int ZW = dta_pkg::ZW;

  logic                 v_r    [N];
  logic signed [W-1:0]  x_r    [N];
  logic signed [W-1:0]  y_r    [N];
  logic signed [ZW-1:0] z_r    [N];
  logic [SIDE_W-1:0]    side_r [N];
  logic                 ld     [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                 pv;
    logic signed [W-1:0]  px, py, x_nxt, y_nxt;
    logic signed [ZW-1:0] pz, z_nxt;
    logic [SIDE_W-1:0]    pside;

    if (k == 0) begin : g_first
      assign pv    = in_valid;
      assign px    = W'(in_x);
      assign py    = W'(in_y);
      assign pz    = '0;
      assign pside = in_side;
    end else begin : g_rest
      assign pv    = v_r[k-1];
      assign px    = x_r[k-1];
      assign py    = y_r[k-1];
      assign pz    = z_r[k-1];
      assign pside = side_r[k-1];
    end

    if (k == N - 1) begin : g_last_ld
      assign ld[k] = !v_r[k] || ld_dn;
    end else begin : g_mid_ld
      assign ld[k] = !v_r[k] || ld[k+1];
    end

    // Once y reaches zero no later step changes anything.
    always_comb begin
      x_nxt = px;
      y_nxt = py;
      z_nxt = pz;
      if (!py[W-1] && (py != '0)) begin
        x_nxt = px + (py >>> k);
        y_nxt = py - (px >>> k);
        z_nxt = pz + dta_pkg::atan_q16(k);
      end else if (py[W-1]) begin
        x_nxt = px - (py >>> k);
        y_nxt = py + (px >>> k);
        z_nxt = pz - dta_pkg::atan_q16(k);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        x_r[k]    <= x_nxt;
        y_r[k]    <= y_nxt;
        z_r[k]    <= z_nxt;
        side_r[k] <= pside;
      end
    end
  end

  assign ld_up     = ld[0];
  assign out_valid = v_r[N-1];
  assign out_z     = z_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

// File: design/dihedral_torsion_angle_top.sv
// Top level of the dihedral angle pipeline: vector stages, square root, CORDIC.
// Depends on dta_pkg, dta_isqrt and dta_cordic.
//
// One point quadruple is taken per cycle while in_ready is high; its angle passes through
// eleven stages of differences, cross products, normalising shifts and sums, a
// 31-stage square root (one root bit per stage) and a 17-stage CORDIC (one
// rotation per stage), then the output register. Every stage carries its own
// valid bit and loads whenever it is empty or its successor moves, so a held
// result stalls only the stages that are full and empty slots still take new
// requests. A result whose plane normal is zero reads 0 with out_degenerate set.
module dihedral_torsion_angle_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_point_i_x,
  input  logic signed [23:0] in_point_i_y,
  input  logic signed [23:0] in_point_i_z,
  input  logic signed [23:0] in_point_j_x,
  input  logic signed [23:0] in_point_j_y,
  input  logic signed [23:0] in_point_j_z,
  input  logic signed [23:0] in_point_k_x,
  input  logic signed [23:0] in_point_k_y,
  input  logic signed [23:0] in_point_k_z,
  input  logic signed [23:0] in_point_l_x,
  input  logic signed [23:0] in_point_l_y,
  input  logic signed [23:0] in_point_l_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_torsion_angle,
  output logic               out_degenerate
);

  localparam int SQ_SIDE = 3 + dta_pkg::SQRT_STEPS;
  localparam int CO_SIDE = 3;
  localparam int ZW      = dta_pkg::ZW;

  // Stage valid bits and load enables.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9, ld10, ld11, ldo;
  logic sq_ld_up, co_ld_up;

  // Stage 1: edge vectors.
  logic signed [24:0] ij_r [3], kj_r [3], kl_r [3];
  // Stage 2: cross product terms.
  logic signed [49:0] p1_r [6], p2_r [6];
  logic signed [24:0] kj2_r [3];
  // Stage 3: normals.
  logic signed [50:0] n1_r [3], n2_r [3];
  logic signed [24:0] kj3_r [3];
  // Stage 4: degeneracy and normal shifts.
  logic signed [50:0] n1f_r [3], n2f_r [3];
  logic signed [24:0] kj4_r [3];
  logic [5:0]         s1_r, s2_r;
  logic               dg4_r;
  // Stage 5: shifted normals.
  logic signed [29:0] n1h_r [3], n2h_r [3];
  logic signed [24:0] kj5_r [3];
  logic               dg5_r;
  // Stage 6: dot and cross terms of the normals.
  logic signed [59:0] dp_r [3], cp_r [6];
  logic signed [24:0] kj6_r [3];
  logic               dg6_r;
  // Stage 7: dot product and cross product.
  logic signed [61:0] xd_r;
  logic signed [60:0] c_r [3];
  logic signed [24:0] kj7_r [3];
  logic               dg7_r;
  // Stage 8: common shift.
  logic signed [61:0] xd8_r;
  logic signed [60:0] c8_r [3];
  logic signed [24:0] kj8_r [3];
  logic [5:0]         sc_r;
  logic               dg8_r;
  // Stage 9: shifted dot and cross.
  logic signed [30:0] xs_r, cs_r [3];
  logic signed [24:0] kj9_r [3];
  logic               dg9_r;
  // Stage 10: squares and sign terms.
  logic [61:0]        sq_r [3];
  logic signed [55:0] dt_r [3];
  logic signed [30:0] xs10_r;
  logic               dg10_r;
  // Stage 11: radicand, sign and |X|.
  logic [61:0]        rad_r;
  logic [30:0]        xabs_r;
  logic               neg_r, xneg_r, dg11_r;

  assign ldo  = !out_valid || out_ready;
  assign ld11 = !v11_r || sq_ld_up;
  assign ld10 = !v10_r || ld11;
  assign ld9  = !v9_r  || ld10;
  assign ld8  = !v8_r  || ld9;
  assign ld7  = !v7_r  || ld8;
  assign ld6  = !v6_r  || ld7;
  assign ld5  = !v5_r  || ld6;
  assign ld4  = !v4_r  || ld5;
  assign ld3  = !v3_r  || ld4;
  assign ld2  = !v2_r  || ld3;
  assign ld1  = !v1_r  || ld2;
  assign in_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0; v7_r <= 1'b0; v8_r <= 1'b0;
      v9_r <= 1'b0; v10_r <= 1'b0; v11_r <= 1'b0;
    end else begin
      if (ld1)  v1_r  <= in_valid;
      if (ld2)  v2_r  <= v1_r;
      if (ld3)  v3_r  <= v2_r;
      if (ld4)  v4_r  <= v3_r;
      if (ld5)  v5_r  <= v4_r;
      if (ld6)  v6_r  <= v5_r;
      if (ld7)  v7_r  <= v6_r;
      if (ld8)  v8_r  <= v7_r;
      if (ld9)  v9_r  <= v8_r;
      if (ld10) v10_r <= v9_r;
      if (ld11) v11_r <= v10_r;
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (ld1) begin
      ij_r[0] <= 25'(in_point_i_x) - 25'(in_point_j_x);
      ij_r[1] <= 25'(in_point_i_y) - 25'(in_point_j_y);
      ij_r[2] <= 25'(in_point_i_z) - 25'(in_point_j_z);
      kj_r[0] <= 25'(in_point_k_x) - 25'(in_point_j_x);
      kj_r[1] <= 25'(in_point_k_y) - 25'(in_point_j_y);
      kj_r[2] <= 25'(in_point_k_z) - 25'(in_point_j_z);
      kl_r[0] <= 25'(in_point_k_x) - 25'(in_point_l_x);
      kl_r[1] <= 25'(in_point_k_y) - 25'(in_point_l_y);
      kl_r[2] <= 25'(in_point_k_z) - 25'(in_point_l_z);
    end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (ld2) begin
      p1_r[0] <= ij_r[1] * kj_r[2];
      p1_r[1] <= ij_r[2] * kj_r[1];
      p1_r[2] <= ij_r[2] * kj_r[0];
      p1_r[3] <= ij_r[0] * kj_r[2];
      p1_r[4] <= ij_r[0] * kj_r[1];
      p1_r[5] <= ij_r[1] * kj_r[0];
      p2_r[0] <= kj_r[1] * kl_r[2];
      p2_r[1] <= kj_r[2] * kl_r[1];
      p2_r[2] <= kj_r[2] * kl_r[0];
      p2_r[3] <= kj_r[0] * kl_r[2];
      p2_r[4] <= kj_r[0] * kl_r[1];
      p2_r[5] <= kj_r[1] * kl_r[0];
      kj2_r   <= kj_r;
    end
  end

  // Stage 3
  always_ff @(posedge clk) begin
    if (ld3) begin
      for (int i = 0; i < 3; i++) begin
        n1_r[i] <= 51'(p1_r[2*i]) - 51'(p1_r[2*i+1]);
        n2_r[i] <= 51'(p2_r[2*i]) - 51'(p2_r[2*i+1]);
      end
      kj3_r <= kj2_r;
    end
  end

  // Stage 4
  logic [63:0] m1a, m1b, m1c, m2a, m2b, m2c, m1_max, m2_max;
  logic        dg4_nxt;
  always_comb begin
    m1a = dta_pkg::mag64(64'(n1_r[0]));
    m1b = dta_pkg::mag64(64'(n1_r[1]));
    m1c = dta_pkg::mag64(64'(n1_r[2]));
    m2a = dta_pkg::mag64(64'(n2_r[0]));
    m2b = dta_pkg::mag64(64'(n2_r[1]));
    m2c = dta_pkg::mag64(64'(n2_r[2]));
    m1_max = m1a;
    if (m1b > m1_max) m1_max = m1b;
    if (m1c > m1_max) m1_max = m1c;
    m2_max = m2a;
    if (m2b > m2_max) m2_max = m2b;
    if (m2c > m2_max) m2_max = m2c;
    dg4_nxt = (m1_max == '0) || (m2_max == '0);
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s1_r  <= dta_pkg::fit_shift(m1_max, dta_pkg::NORM_FIT);
      s2_r  <= dta_pkg::fit_shift(m2_max, dta_pkg::NORM_FIT);
      dg4_r <= dg4_nxt;
      n1f_r <= n1_r;
      n2f_r <= n2_r;
      kj4_r <= kj3_r;
    end
  end

  // Stage 5
  always_ff @(posedge clk) begin
    if (ld5) begin
      for (int i = 0; i < 3; i++) begin
        n1h_r[i] <= 30'(n1f_r[i] >>> s1_r);
        n2h_r[i] <= 30'(n2f_r[i] >>> s2_r);
      end
      kj5_r <= kj4_r;
      dg5_r <= dg4_r;
    end
  end

  // Stage 6
  always_ff @(posedge clk) begin
    if (ld6) begin
      for (int i = 0; i < 3; i++) begin
        dp_r[i] <= n1h_r[i] * n2h_r[i];
      end
      cp_r[0] <= n1h_r[1] * n2h_r[2];
      cp_r[1] <= n1h_r[2] * n2h_r[1];
      cp_r[2] <= n1h_r[2] * n2h_r[0];
      cp_r[3] <= n1h_r[0] * n2h_r[2];
      cp_r[4] <= n1h_r[0] * n2h_r[1];
      cp_r[5] <= n1h_r[1] * n2h_r[0];
      kj6_r <= kj5_r;
      dg6_r <= dg5_r;
    end
  end

  // Stage 7
  always_ff @(posedge clk) begin
    if (ld7) begin
      xd_r <= 62'(dp_r[0]) + 62'(dp_r[1]) + 62'(dp_r[2]);
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= 61'(cp_r[2*i]) - 61'(cp_r[2*i+1]);
      end
      kj7_r <= kj6_r;
      dg7_r <= dg6_r;
    end
  end

  // Stage 8
  logic [63:0] mc_max, mc_t;
  always_comb begin
    mc_max = dta_pkg::mag64(64'(xd_r));
    for (int i = 0; i < 3; i++) begin
      mc_t = dta_pkg::mag64(64'(c_r[i]));
      if (mc_t > mc_max) mc_max = mc_t;
    end
  end

  always_ff @(posedge clk) begin
    if (ld8) begin
      sc_r  <= dta_pkg::fit_shift(mc_max, dta_pkg::PROD_FIT);
      xd8_r <= xd_r;
      c8_r  <= c_r;
      kj8_r <= kj7_r;
      dg8_r <= dg7_r;
    end
  end

  // Stage 9
  always_ff @(posedge clk) begin
    if (ld9) begin
      xs_r <= 31'(xd8_r >>> sc_r);
      for (int i = 0; i < 3; i++) begin
        cs_r[i] <= 31'(c8_r[i] >>> sc_r);
      end
      kj9_r <= kj8_r;
      dg9_r <= dg8_r;
    end
  end

  // Stage 10
  always_ff @(posedge clk) begin
    if (ld10) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 62'(cs_r[i] * cs_r[i]);
        dt_r[i] <= kj9_r[i] * cs_r[i];
      end
      xs10_r <= xs_r;
      dg10_r <= dg9_r;
    end
  end

  // Stage 11
  logic signed [57:0] dot_nxt;
  assign dot_nxt = 58'(dt_r[0]) + 58'(dt_r[1]) + 58'(dt_r[2]);

  always_ff @(posedge clk) begin
    if (ld11) begin
      rad_r  <= sq_r[0] + sq_r[1] + sq_r[2];
      neg_r  <= !dot_nxt[57] && (dot_nxt != '0);
      xneg_r <= xs10_r[30];
      xabs_r <= xs10_r[30] ? 31'(-xs10_r) : 31'(xs10_r);
      dg11_r <= dg10_r;
    end
  end

  logic                          sq_valid;
  logic [dta_pkg::SQRT_STEPS-1:0] sq_root;
  logic [SQ_SIDE-1:0]            sq_side;

  dta_isqrt #(
    .SIDE_W (SQ_SIDE)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v11_r),
    .in_rad    (rad_r),
    .in_side   ({dg11_r, xneg_r, neg_r, xabs_r}),
    .ld_dn     (co_ld_up),
    .ld_up     (sq_ld_up),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic                 co_valid;
  logic signed [ZW-1:0] co_z;
  logic [CO_SIDE-1:0]   co_side;

  dta_cordic #(
    .SIDE_W (CO_SIDE)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_x      (sq_side[dta_pkg::SQRT_STEPS-1:0]),
    .in_y      (sq_root),
    .in_side   (sq_side[SQ_SIDE-1 -: CO_SIDE]),
    .ld_dn     (ldo),
    .ld_up     (co_ld_up),
    .out_valid (co_valid),
    .out_z     (co_z),
    .out_side  (co_side)
  );

  // Final mapping: fold into [0, pi], round to Q3.13 and apply the sign rule.
  logic signed [ZW:0]  m_q16;
  logic signed [ZW:0]  m_rnd;
  logic [15:0]         m13;
  logic signed [15:0]  ang_nxt;
  logic                dg_o, xneg_o, neg_o;

  assign {dg_o, xneg_o, neg_o} = co_side;

  always_comb begin
    if (xneg_o) begin
      m_q16 = (ZW+1)'(dta_pkg::PI_Q16) - (ZW+1)'(co_z);
    end else begin
      m_q16 = (ZW+1)'(co_z);
    end
    if (m_q16[ZW]) begin
      m_q16 = '0;
    end else if (m_q16 > (ZW+1)'(dta_pkg::PI_Q16)) begin
      m_q16 = (ZW+1)'(dta_pkg::PI_Q16);
    end
    m_rnd = (m_q16 + (ZW+1)'(4)) >>> 3;
    m13   = 16'(m_rnd);
    if (m13 > 16'(dta_pkg::PI_Q13)) m13 = 16'(dta_pkg::PI_Q13);
    ang_nxt = 16'(dta_pkg::PI_Q13) - $signed(m13);
    if (neg_o || (m13 == '0)) ang_nxt = -ang_nxt;
    if (dg_o) ang_nxt = '0;
  end

  logic               out_valid_r;
  logic signed [15:0] angle_r;
  logic               degen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ldo) begin
      out_valid_r <= co_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ldo) begin
      angle_r <= ang_nxt;
      degen_r <= dg_o;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_torsion_angle = angle_r;
  assign out_degenerate    = degen_r;

endmodule

// File: design/dta_checker.sv
// Port-level checks of the dihedral angle block, bound to its top level.
// Depends on dihedral_torsion_angle_top for the bind target and on dta_pkg.
module dta_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_torsion_angle,
  input logic               out_degenerate
);

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_torsion_angle == 16'sd0)
    else $error("degenerate result with a nonzero angle");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_torsion_angle >= -16'(dta_pkg::PI_Q13)) &&
                  (out_torsion_angle <= 16'(dta_pkg::PI_Q13)))
    else $error("angle outside minus pi to pi");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_torsion_angle) &&
                                $stable(out_degenerate))
    else $error("stalled result changed or vanished");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind dihedral_torsion_angle_top dta_checker u_dta_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_torsion_angle (out_torsion_angle),
  .out_degenerate    (out_degenerate)
);

// File: verif/testbench.sv
// Self-checking testbench for dihedral_torsion_angle_top: random and directed point
// quadruples, an integer angle predictor, and a scoreboard on the result channel.
// Depends on dta_pkg and the design files.
module testbench;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               degen;
  } angle_t;

  typedef logic signed [23:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t pt [12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] out_torsion_angle;
  logic out_degenerate;

  angle_t angle_queue[$];
  int mismatches = 0;
  int long_hold = 0;
  bit rx_random = 1'b1;
  bit tx_bursty = 1'b1;

  dihedral_torsion_angle_top DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_point_i_x(pt[0]), .in_point_i_y(pt[1]), .in_point_i_z(pt[2]),
    .in_point_j_x(pt[3]), .in_point_j_y(pt[4]), .in_point_j_z(pt[5]),
    .in_point_k_x(pt[6]), .in_point_k_y(pt[7]), .in_point_k_z(pt[8]),
    .in_point_l_x(pt[9]), .in_point_l_y(pt[10]), .in_point_l_z(pt[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_torsion_angle(out_torsion_angle), .out_degenerate(out_degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int shift_to_fit(longint m, int bits);
    int s;
    s = 0;
    while ((m >>> s) >= (64'sd1 <<< bits)) s++;
    return s;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic angle_t predict_torsion(coord_t p [12]);
    longint ij[3], kj[3], kl[3], n1[3], n2[3], c[3];
    longint xd, x, y, z, m, dot, mx, nx, ny, r;
    int s1, s2, sc;
    angle_t res;
    for (int i = 0; i < 3; i++) begin
      ij[i] = longint'(p[i]) - longint'(p[3+i]);
      kj[i] = longint'(p[6+i]) - longint'(p[3+i]);
      kl[i] = longint'(p[6+i]) - longint'(p[9+i]);
    end
    n1[0] = ij[1]*kj[2] - ij[2]*kj[1];
    n1[1] = ij[2]*kj[0] - ij[0]*kj[2];
    n1[2] = ij[0]*kj[1] - ij[1]*kj[0];
    n2[0] = kj[1]*kl[2] - kj[2]*kl[1];
    n2[1] = kj[2]*kl[0] - kj[0]*kl[2];
    n2[2] = kj[0]*kl[1] - kj[1]*kl[0];
    if ((n1[0] == 0 && n1[1] == 0 && n1[2] == 0) ||
        (n2[0] == 0 && n2[1] == 0 && n2[2] == 0)) begin
      res.angle = '0;
      res.degen = 1'b1;
      return res;
    end
    mx = abs64(n1[0]);
    if (abs64(n1[1]) > mx) mx = abs64(n1[1]);
    if (abs64(n1[2]) > mx) mx = abs64(n1[2]);
    s1 = shift_to_fit(mx, dta_pkg::NORM_FIT);
    mx = abs64(n2[0]);
    if (abs64(n2[1]) > mx) mx = abs64(n2[1]);
    if (abs64(n2[2]) > mx) mx = abs64(n2[2]);
    s2 = shift_to_fit(mx, dta_pkg::NORM_FIT);
    for (int i = 0; i < 3; i++) begin
      n1[i] = floor_shift(n1[i], s1);
      n2[i] = floor_shift(n2[i], s2);
    end
    xd = n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2];
    c[0] = n1[1]*n2[2] - n1[2]*n2[1];
    c[1] = n1[2]*n2[0] - n1[0]*n2[2];
    c[2] = n1[0]*n2[1] - n1[1]*n2[0];
    mx = abs64(xd);
    for (int i = 0; i < 3; i++) if (abs64(c[i]) > mx) mx = abs64(c[i]);
    sc = shift_to_fit(mx, dta_pkg::PROD_FIT);
    xd = floor_shift(xd, sc);
    for (int i = 0; i < 3; i++) c[i] = floor_shift(c[i], sc);
    y = int_sqrt(c[0]*c[0] + c[1]*c[1] + c[2]*c[2]);
    x = abs64(xd);
    z = 0;
    for (int i = 0; i < dta_pkg::CORDIC_STEPS; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z = z + longint'(dta_pkg::atan_q16(i));
      end else begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z = z - longint'(dta_pkg::atan_q16(i));
      end
      x = nx;
      y = ny;
    end
    m = xd < 0 ? dta_pkg::PI_Q16 - z : z;
    if (m < 0) m = 0;
    if (m > dta_pkg::PI_Q16) m = dta_pkg::PI_Q16;
    m = (m + 4) >>> 3;
    if (m > dta_pkg::PI_Q13) m = dta_pkg::PI_Q13;
    dot = kj[0]*c[0] + kj[1]*c[1] + kj[2]*c[2];
    r = dta_pkg::PI_Q13 - m;
    if (dot > 0 || m == 0) r = -r;
    res.angle = 16'(r);
    res.degen = 1'b0;
    return res;
  endfunction

  // Sends one request, keeping valid high across back-to-back requests.
  task automatic send_points(coord_t p [12]);
    pt = p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    angle_queue.push_back(predict_torsion(p));
    @(negedge clk);
    if (tx_bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (angle_queue.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 4))
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return coord_t'($signed($urandom_range(0, 60000)) - 30000);
    endcase
  endfunction

  task automatic test_directed();
    coord_t p [12];
    // Extremes of every field.
    foreach (p[i]) p[i] = 24'sh7fffff;
    send_points(p);
    foreach (p[i]) p[i] = 24'sh800000;
    send_points(p);
    foreach (p[i]) p[i] = (i % 2) ? 24'sh800000 : 24'sh7fffff;
    send_points(p);
    foreach (p[i]) p[i] = (i % 3) ? 24'sh7fffff : 24'sh800000;
    send_points(p);
    // Two planar quadruples, both with parallel normals (angle between normals exactly zero).
    p = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 0, 1024, 1024};
    p[9] = 1024; p[10] = 2048; p[11] = 0;
    send_points(p);
    p = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 1024, 1024, 0};
    send_points(p);
    // Right angles of either sign.
    p = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 0, 1024, 1024};
    send_points(p);
    p = '{1024, 0, 0, 0, 0, 0, 0, 1024, 0, 0, 1024, -1024};
    send_points(p);
    // J equal to K, and collinear points on each side.
    p = '{5, 6, 7, 100, 200, 300, 100, 200, 300, 9, 8, 7};
    send_points(p);
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 1, 3};
    send_points(p);
    p = '{5, 1, 3, 1, 1, 1, 2, 2, 2, 3, 3, 3};
    send_points(p);
    p = '{1, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1, 1};
    send_points(p);
    p = '{-1, 0, 0, 0, 0, 0, 0, -1, 0, 0, 0, -1};
    send_points(p);
  endtask

  task automatic test_random(int count);
    coord_t p [12];
    for (int n = 0; n < count; n++) begin
      foreach (p[i]) p[i] = rand_coord();
      // Make some quadruples near-degenerate.
      if ($urandom_range(0, 15) == 0) p[6+$urandom_range(0, 2)] = p[3+$urandom_range(0, 2)];
      if ($urandom_range(0, 20) == 0) for (int i = 0; i < 3; i++) p[6+i] = p[3+i];
      send_points(p);
    end
  endtask

  task automatic test_backpressure();
    coord_t p [12];
    tx_bursty = 1'b0;
    long_hold = 300;
    for (int n = 0; n < 150; n++) begin
      foreach (p[i]) p[i] = rand_coord();
      send_points(p);
    end
    tx_bursty = 1'b1;
    wait_drained();
  endtask

  task automatic test_streaming();
    rx_random = 1'b0;
    tx_bursty = 1'b0;
    test_random(200);
    wait_drained();
    rx_random = 1'b1;
    tx_bursty = 1'b1;
  endtask

  // Receiver stall pattern, with an occasional long hold-off.
  always @(negedge clk) begin
    if (long_hold > 0) begin
      out_ready <= 1'b0;
      long_hold <= long_hold - 1;
    end else if (rx_random) begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    angle_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result angle=%0d", out_torsion_angle);
      end else begin
        exp_r = angle_queue.pop_front();
        if (exp_r.angle !== out_torsion_angle || exp_r.degen !== out_degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected angle=%0d degen=%0b, got angle=%0d degen=%0b",
                     exp_r.angle, exp_r.degen, out_torsion_angle, out_degenerate);
        end
      end
    end
  end

  initial begin
    foreach (pt[i]) pt[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random(1490);
    test_streaming();
    wait_drained();
    repeat (80) @(negedge clk);
    if (mismatches == 0 && angle_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
design/dta_pkg.sv
design/dta_isqrt.sv
design/dta_cordic.sv
design/dihedral_torsion_angle_top.sv
design/dta_checker.sv
verif/testbench.sv
